// ----- rtl/assert_macros.svh -----
// Assertion macros included by the execute stage RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that also runs during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/adpe_pkg.sv -----
// Types and constants of the data-processing execute block.
package adpe_pkg;

  localparam int WORD_W    = 32;
  localparam int NUM_REGS  = 16;
  localparam int REG_IDX_W = 4;
  localparam int FLAGS_W   = 4;
  localparam int RD_PORTS  = 3;

  // Read ports of the register file
  localparam int PORT_RN = 0;
  localparam int PORT_RM = 1;
  localparam int PORT_RS = 2;

  localparam logic [REG_IDX_W-1:0] REG_PC = 4'd15;

  typedef enum logic [3:0] {
    OP_AND = 4'h0, OP_EOR = 4'h1, OP_SUB = 4'h2, OP_RSB = 4'h3,
    OP_ADD = 4'h4, OP_ADC = 4'h5, OP_SBC = 4'h6, OP_RSC = 4'h7,
    OP_TST = 4'h8, OP_TEQ = 4'h9, OP_CMP = 4'hA, OP_CMN = 4'hB,
    OP_ORR = 4'hC, OP_MOV = 4'hD, OP_BIC = 4'hE, OP_MVN = 4'hF
  } opcode_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
  } shift_kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] op;
    logic              c;
  } shift_res_t;

  // Accepted input item
  typedef struct packed {
    logic                 kind;
    logic [WORD_W-1:0]    instruction;
    logic [REG_IDX_W-1:0] load_index;
    logic [WORD_W-1:0]    load_value;
    logic                 mode_has_spsr;
    logic [WORD_W-1:0]    saved_status;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [REG_IDX_W-1:0] dest_index;
    logic [WORD_W-1:0]    dest_value;
    logic                 dest_written;
    logic [FLAGS_W-1:0]   flags_out;
    logic                 status_restored;
    logic                 undefined_fault;
  } out_item_t;

endpackage

// ----- rtl/arm_data_processing_execute.sv -----
// ARMv5 data-processing execute stage: register file, barrel shifter, ALU, flags.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | kind, instruction, load_*, mode, SPSR
//  out_    | output    | out_valid / out_ready | dest_*, flags_out, restored, fault
//
// One item per cycle sustained while out_ready is high; out_valid rises when the item moves
// from the input stage (register file read) through shift/ALU into the result register.
// The register file and flags are written when an item moves into the result register;
// a same-cycle write is forwarded to the item entering behind it.
// Reset (synchronous, rst_n low) empties both stages, clears NZCV and marks all
// registers invalid, so they read as zero until written; no clearing pass.
// A stalled output holds the result; in_ready stays high while the input stage can drain.
`include "assert_macros.svh"

module arm_data_processing_execute
  import adpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [WORD_W-1:0]    in_instruction,
  input  logic [REG_IDX_W-1:0] in_load_index,
  input  logic [WORD_W-1:0]    in_load_value,
  input  logic                 in_mode_has_spsr,
  input  logic [WORD_W-1:0]    in_saved_status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [REG_IDX_W-1:0] out_dest_index,
  output logic [WORD_W-1:0]    out_dest_value,
  output logic                 out_dest_written,
  output logic [FLAGS_W-1:0]   out_flags_out,
  output logic                 out_status_restored,
  output logic                 out_undefined_fault
);

  // Shifted operand: amount from Rs[7:0] or the immediate field, zero amount handled by caller
  function automatic shift_res_t shift_by_amount(input shift_kind_t sk,
                                                 input logic [7:0] amt,
                                                 input logic [WORD_W-1:0] rm);
    shift_res_t        r;
    logic [4:0]        a5;
    logic [4:0]        lsl_idx;
    logic [4:0]        low_idx;
    logic [2*WORD_W-1:0] rot;
    a5      = amt[4:0];
    lsl_idx = 5'(6'd32 - {1'b0, a5});
    low_idx = a5 - 5'd1;
    rot     = {rm, rm} >> a5;
    r.op    = '0;
    r.c     = 1'b0;
    unique case (sk)
      SH_LSL: begin
        if (amt < 8'd32) begin
          r.op = rm << a5;
          r.c  = rm[lsl_idx];
        end else if (amt == 8'd32) begin
          r.c = rm[0];
        end
      end
      SH_LSR: begin
        if (amt < 8'd32) begin
          r.op = rm >> a5;
          r.c  = rm[low_idx];
        end else if (amt == 8'd32) begin
          r.c = rm[WORD_W-1];
        end
      end
      SH_ASR: begin
        if (amt < 8'd32) begin
          r.op = $unsigned($signed(rm) >>> a5);
          r.c  = rm[low_idx];
        end else begin
          r.op = {WORD_W{rm[WORD_W-1]}};
          r.c  = rm[WORD_W-1];
        end
      end
      SH_ROR: begin
        if (a5 == 5'd0) begin
          r.op = rm;
          r.c  = rm[WORD_W-1];
        end else begin
          r.op = rot[WORD_W-1:0];
          r.c  = rm[low_idx];
        end
      end
    endcase
    return r;
  endfunction

  // Pipeline control
  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  logic      advance;
  logic      accept;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign accept   = in_valid && in_ready;

  // Register file: one RAM copy per read port, all written alike
  logic [NUM_REGS-1:0]  reg_vld_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_addr;
  logic [WORD_W-1:0]    wr_data;
  logic [REG_IDX_W-1:0] rd_addr [RD_PORTS];
  logic [WORD_W-1:0]    ram_q   [RD_PORTS];
  logic [RD_PORTS-1:0]  hit_r;
  logic [RD_PORTS-1:0]  vld_r;
  logic [WORD_W-1:0]    fwd_r;
  logic [WORD_W-1:0]    opnd    [RD_PORTS];

  assign rd_addr[PORT_RN] = in_instruction[19:16];
  assign rd_addr[PORT_RM] = in_instruction[3:0];
  assign rd_addr[PORT_RS] = in_instruction[11:8];

  for (genvar p = 0; p < RD_PORTS; p++) begin : g_rf
    adpe_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_REGS)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (accept),
      .raddr (rd_addr[p]),
      .rdata (ram_q[p])
    );
    // forwarded write wins, unwritten entry reads zero
    assign opnd[p] = hit_r[p] ? fwd_r : (vld_r[p] ? ram_q[p] : '0);
  end

  // Bypass and valid-bit capture for the entering item
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_r <= wr_data;
      for (int p = 0; p < RD_PORTS; p++) begin
        hit_r[p] <= wr_en && (wr_addr == rd_addr[p]);
        vld_r[p] <= reg_vld_r[rd_addr[p]];
      end
    end
  end

  // Condition flags
  logic [FLAGS_W-1:0] flags_r;
  logic [FLAGS_W-1:0] flags_nxt;

  // Decode
  logic [WORD_W-1:0]    ins;
  opcode_t              opcode;
  logic                 s_bit;
  logic [REG_IDX_W-1:0] rd;
  logic                 c_flag;
  logic                 v_flag;
  logic                 compare;

  assign ins     = in_item_r.instruction;
  assign opcode  = opcode_t'(ins[24:21]);
  assign s_bit   = ins[20];
  assign rd      = ins[15:12];
  assign c_flag  = flags_r[1];
  assign v_flag  = flags_r[0];
  assign compare = (ins[24:23] == 2'b10);

  // Shifter operand
  shift_res_t          sh;
  logic [WORD_W-1:0]   imm32;
  logic [4:0]          imm_rot;
  logic [2*WORD_W-1:0] imm_wide;
  logic [4:0]          sh_imm;
  logic [7:0]          sh_amt;
  shift_kind_t         sh_kind;

  assign imm32    = {24'd0, ins[7:0]};
  assign imm_rot  = {ins[11:8], 1'b0};
  assign imm_wide = {imm32, imm32} >> imm_rot;
  assign sh_imm   = ins[11:7];
  assign sh_kind  = shift_kind_t'(ins[6:5]);

  always_comb begin
    sh_amt = opnd[PORT_RS][7:0];
    if (!ins[4]) begin
      // immediate zero means 32 for LSR/ASR
      if (sh_imm == 5'd0 && (sh_kind == SH_LSR || sh_kind == SH_ASR)) begin
        sh_amt = 8'd32;
      end else begin
        sh_amt = {3'd0, sh_imm};
      end
    end
    priority if (ins[25]) begin
      sh.op = imm_wide[WORD_W-1:0];
      sh.c  = (ins[11:8] == 4'd0) ? c_flag : imm_wide[WORD_W-1];
    end else if (!ins[4] && sh_imm == 5'd0 && sh_kind == SH_ROR) begin
      // RRX
      sh.op = {c_flag, opnd[PORT_RM][WORD_W-1:1]};
      sh.c  = opnd[PORT_RM][0];
    end else if (sh_amt == 8'd0) begin
      sh.op = opnd[PORT_RM];
      sh.c  = c_flag;
    end else begin
      sh = shift_by_amount(sh_kind, sh_amt, opnd[PORT_RM]);
    end
  end

  // ALU: one shared adder, logic ops beside it
  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] add_x;
  logic [WORD_W-1:0] add_y;
  logic              add_cin;
  logic [WORD_W:0]   sum;
  logic              add_v;
  logic [WORD_W-1:0] res;
  logic              res_c;
  logic              res_v;

  assign a = opnd[PORT_RN];

  always_comb begin
    add_x   = a;
    add_y   = sh.op;
    add_cin = 1'b0;
    unique case (opcode)
      OP_SUB, OP_CMP: begin add_y = ~sh.op; add_cin = 1'b1; end
      OP_RSB:         begin add_x = sh.op; add_y = ~a; add_cin = 1'b1; end
      OP_ADC:         begin add_cin = c_flag; end
      OP_SBC:         begin add_y = ~sh.op; add_cin = c_flag; end
      OP_RSC:         begin add_x = sh.op; add_y = ~a; add_cin = c_flag; end
      OP_AND, OP_EOR, OP_ADD, OP_TST, OP_TEQ, OP_CMN,
      OP_ORR, OP_MOV, OP_BIC, OP_MVN: begin end
    endcase
  end

  assign sum   = {1'b0, add_x} + {1'b0, add_y} + {{WORD_W{1'b0}}, add_cin};
  assign add_v = ~(add_x[WORD_W-1] ^ add_y[WORD_W-1]) & (add_x[WORD_W-1] ^ sum[WORD_W-1]);

  always_comb begin
    res   = sum[WORD_W-1:0];
    res_c = sum[WORD_W];
    res_v = add_v;
    unique case (opcode)
      OP_AND, OP_TST: begin res = a & sh.op;  res_c = sh.c; res_v = v_flag; end
      OP_EOR, OP_TEQ: begin res = a ^ sh.op;  res_c = sh.c; res_v = v_flag; end
      OP_ORR:         begin res = a | sh.op;  res_c = sh.c; res_v = v_flag; end
      OP_MOV:         begin res = sh.op;      res_c = sh.c; res_v = v_flag; end
      OP_BIC:         begin res = a & ~sh.op; res_c = sh.c; res_v = v_flag; end
      OP_MVN:         begin res = ~sh.op;     res_c = sh.c; res_v = v_flag; end
      OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC,
      OP_CMP, OP_CMN: begin end
    endcase
  end

  // Result item, flags and register write
  out_item_t out_nxt;
  logic [FLAGS_W-1:0] computed;

  assign computed = {res[WORD_W-1], (res == '0), res_c, res_v};

  always_comb begin
    out_nxt   = '0;
    flags_nxt = flags_r;
    wr_en     = 1'b0;
    wr_addr   = rd;
    wr_data   = res;
    if (in_item_r.kind) begin
      wr_en                = advance;
      wr_addr              = in_item_r.load_index;
      wr_data              = in_item_r.load_value;
      out_nxt.dest_index   = in_item_r.load_index;
      out_nxt.dest_value   = in_item_r.load_value;
      out_nxt.dest_written = 1'b1;
    end else begin
      out_nxt.dest_index = rd;
      if (compare) begin
        flags_nxt = computed;
      end else begin
        wr_en                = advance;
        out_nxt.dest_value   = res;
        out_nxt.dest_written = 1'b1;
        if (s_bit && rd == REG_PC) begin
          if (in_item_r.mode_has_spsr) begin
            flags_nxt               = in_item_r.saved_status[31:28];
            out_nxt.status_restored = 1'b1;
          end else begin
            out_nxt.undefined_fault = 1'b1;
          end
        end else if (s_bit) begin
          flags_nxt = computed;
        end
      end
    end
    out_nxt.flags_out = flags_nxt;
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      flags_r   <= '0;
      reg_vld_r <= '0;
    end else begin
      if (accept) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        flags_r   <= flags_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (wr_en) begin
        reg_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r.kind          <= in_kind;
      in_item_r.instruction   <= in_instruction;
      in_item_r.load_index    <= in_load_index;
      in_item_r.load_value    <= in_load_value;
      in_item_r.mode_has_spsr <= in_mode_has_spsr;
      in_item_r.saved_status  <= in_saved_status;
    end
    if (advance) begin
      out_item_r <= out_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_dest_index      = out_item_r.dest_index;
  assign out_dest_value      = out_item_r.dest_value;
  assign out_dest_written    = out_item_r.dest_written;
  assign out_flags_out       = out_item_r.flags_out;
  assign out_status_restored = out_item_r.status_restored;
  assign out_undefined_fault = out_item_r.undefined_fault;

  // Checks
  `ASSERT_CLK(a_in_hold, in_vld_r && !advance |=> in_vld_r, "input stage lost an item")
  `ASSERT_CLK(a_adv_out, advance |=> out_vld_r, "advanced item missing at output")
  `ASSERT_CLK(a_flags_eq, out_vld_r |-> out_flags_out == flags_r, "flags out of step with state")
  `ASSERT_CLK(a_excl, out_vld_r |-> !(out_status_restored && out_undefined_fault),
              "restore and fault both set")
  `ASSERT_CLK(a_nowrite_zero, out_vld_r && !out_dest_written |-> out_dest_value == '0,
              "compare result carries a value")

endmodule

// ----- rtl/adpe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module adpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- bench/tb_arm_data_processing_execute.sv -----
// Self-checking testbench for the ARMv5 data-processing execute stage.
module tb_arm_data_processing_execute;
  import adpe_pkg::*;

  localparam int NUM_RANDOM  = 1627;
  localparam int TOTAL_ITEMS = 1650;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_WAIT  = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_kind = 1'b0;
  logic [WORD_W-1:0]    in_instruction = '0;
  logic [REG_IDX_W-1:0] in_load_index = '0;
  logic [WORD_W-1:0]    in_load_value = '0;
  logic                 in_mode_has_spsr = 1'b0;
  logic [WORD_W-1:0]    in_saved_status = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [REG_IDX_W-1:0] out_dest_index;
  logic [WORD_W-1:0]    out_dest_value;
  logic                 out_dest_written;
  logic [FLAGS_W-1:0]   out_flags_out;
  logic                 out_status_restored;
  logic                 out_undefined_fault;

  arm_data_processing_execute i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_instruction      (in_instruction),
    .in_load_index       (in_load_index),
    .in_load_value       (in_load_value),
    .in_mode_has_spsr    (in_mode_has_spsr),
    .in_saved_status     (in_saved_status),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_dest_index      (out_dest_index),
    .out_dest_value      (out_dest_value),
    .out_dest_written    (out_dest_written),
    .out_flags_out       (out_flags_out),
    .out_status_restored (out_status_restored),
    .out_undefined_fault (out_undefined_fault)
  );

  // Shadow architectural state
  logic [WORD_W-1:0]  gpr [NUM_REGS];
  logic [FLAGS_W-1:0] nzcv;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  in_item_t  drv_item;

  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_loads    = 0;
  int n_execs    = 0;
  int n_restores = 0;
  int n_faults   = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  int cycle_cnt  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] ror32(logic [WORD_W-1:0] v, int n);
    logic [2*WORD_W-1:0] t;
    t = {v, v} >> n;
    return t[WORD_W-1:0];
  endfunction

  // Arithmetic shift right, sign bit copied in from the top
  function automatic logic [WORD_W-1:0] asr32(logic [WORD_W-1:0] v, int n);
    logic [WORD_W-1:0] t;
    t = $signed(v) >>> n;
    return t;
  endfunction

  // Returns {carry, overflow, sum} of a + b + cin
  function automatic logic [WORD_W+1:0] add_cv(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                               logic cin);
    logic [WORD_W:0]   s;
    logic [WORD_W-1:0] r;
    s = {1'b0, a} + {1'b0, b} + {{WORD_W{1'b0}}, cin};
    r = s[WORD_W-1:0];
    return {s[WORD_W], ~(a[31] ^ b[31]) & (a[31] ^ r[31]), r};
  endfunction

  // Predicts the result of one item and updates the shadow state
  function automatic out_item_t execute_item(in_item_t it);
    out_item_t         res_item;
    logic [WORD_W-1:0] ins, a, rm, op, res;
    logic              cf, sc, c, v, is_cmp;
    opcode_t           opc;
    shift_kind_t       sk;
    int                n, amt;
    res_item = '0;
    if (it.kind) begin
      gpr[it.load_index] = it.load_value;
      res_item.dest_index   = it.load_index;
      res_item.dest_value   = it.load_value;
      res_item.dest_written = 1'b1;
      res_item.flags_out    = nzcv;
      n_loads++;
      return res_item;
    end
    n_execs++;
    ins = it.instruction;
    opc = opcode_t'(ins[24:21]);
    sk  = shift_kind_t'(ins[6:5]);
    cf  = nzcv[1];
    a   = gpr[ins[19:16]];
    rm  = gpr[ins[3:0]];

    // Barrel shifter
    if (ins[25]) begin
      n  = 2 * int'(ins[11:8]);
      op = ror32({24'd0, ins[7:0]}, n);
      sc = (n == 0) ? cf : op[31];
    end else if (!ins[4]) begin
      n = int'(ins[11:7]);
      case (sk)
        SH_LSL: begin
          op = (n == 0) ? rm : rm << n;
          sc = (n == 0) ? cf : rm[32-n];
        end
        SH_LSR: begin
          op = (n == 0) ? '0 : rm >> n;
          sc = (n == 0) ? rm[31] : rm[n-1];
        end
        SH_ASR: begin
          op = (n == 0) ? {WORD_W{rm[31]}} : asr32(rm, n);
          sc = (n == 0) ? rm[31] : rm[n-1];
        end
        default: begin
          // a zero amount means rotate right through carry
          op = (n == 0) ? {cf, rm[31:1]} : ror32(rm, n);
          sc = (n == 0) ? rm[0] : rm[n-1];
        end
      endcase
    end else begin
      amt = int'(gpr[ins[11:8]][7:0]);
      if (amt == 0) begin
        op = rm;
        sc = cf;
      end else begin
        case (sk)
          SH_LSL: begin
            op = (amt < 32) ? rm << amt : '0;
            sc = (amt < 32) ? rm[32-amt] : (amt == 32) ? rm[0] : 1'b0;
          end
          SH_LSR: begin
            op = (amt < 32) ? rm >> amt : '0;
            sc = (amt < 32) ? rm[amt-1] : (amt == 32) ? rm[31] : 1'b0;
          end
          SH_ASR: begin
            op = (amt < 32) ? asr32(rm, amt) : {WORD_W{rm[31]}};
            sc = (amt < 32) ? rm[amt-1] : rm[31];
          end
          default: begin
            // multiples of 32 leave Rm alone, carry from bit 31
            n  = amt % 32;
            op = ror32(rm, n);
            sc = (n == 0) ? rm[31] : rm[n-1];
          end
        endcase
      end
    end

    // ALU
    c = sc;
    v = nzcv[0];
    case (opc)
      OP_AND, OP_TST: res = a & op;
      OP_EOR, OP_TEQ: res = a ^ op;
      OP_SUB, OP_CMP: {c, v, res} = add_cv(a, ~op, 1'b1);
      OP_RSB:         {c, v, res} = add_cv(op, ~a, 1'b1);
      OP_ADD, OP_CMN: {c, v, res} = add_cv(a, op, 1'b0);
      OP_ADC:         {c, v, res} = add_cv(a, op, cf);
      OP_SBC:         {c, v, res} = add_cv(a, ~op, cf);
      OP_RSC:         {c, v, res} = add_cv(op, ~a, cf);
      OP_ORR:         res = a | op;
      OP_MOV:         res = op;
      OP_BIC:         res = a & ~op;
      default:        res = ~op;
    endcase

    case (opc)
      OP_TST, OP_TEQ, OP_CMP, OP_CMN: is_cmp = 1'b1;
      default:                        is_cmp = 1'b0;
    endcase

    // Flag and register file update
    if (is_cmp) begin
      nzcv = {res[31], res == '0, c, v};
    end else begin
      gpr[ins[15:12]] = res;
      res_item.dest_value   = res;
      res_item.dest_written = 1'b1;
      if (ins[20] && ins[15:12] == REG_PC) begin
        if (it.mode_has_spsr) begin
          nzcv = it.saved_status[31:28];
          res_item.status_restored = 1'b1;
          n_restores++;
        end else begin
          res_item.undefined_fault = 1'b1;
          n_faults++;
        end
      end else if (ins[20]) begin
        nzcv = {res[31], res == '0, c, v};
      end
    end
    res_item.dest_index = ins[15:12];
    res_item.flags_out  = nzcv;
    return res_item;
  endfunction

  // Stimulus helpers
  task automatic queue_item(logic kind, logic [WORD_W-1:0] ins, logic [REG_IDX_W-1:0] idx,
                            logic [WORD_W-1:0] val, logic mode, logic [WORD_W-1:0] spsr);
    in_item_t it;
    it.kind          = kind;
    it.instruction   = ins;
    it.load_index    = idx;
    it.load_value    = val;
    it.mode_has_spsr = mode;
    it.saved_status  = spsr;
    pending_items.push_back(it);
  endtask

  task automatic queue_load(logic [REG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    queue_item(1'b1, $urandom, idx, val, 1'($urandom_range(0, 1)), $urandom);
  endtask

  task automatic queue_exec(logic [WORD_W-1:0] ins, logic mode, logic [WORD_W-1:0] spsr);
    queue_item(1'b0, ins, 4'($urandom), $urandom, mode, spsr);
  endtask

  // Condition field and bits 27..26 are don't-care, so fill them at random
  function automatic logic [WORD_W-1:0] dp_word(opcode_t opc, logic s, logic [3:0] rn,
                                                logic [3:0] rd, logic imm, logic [11:0] sh);
    logic [5:0] junk;
    junk = 6'($urandom);
    return {junk, imm, opc, s, rn, rd, sh};
  endfunction

  function automatic logic [11:0] sh_imm(logic [4:0] n, shift_kind_t sk, logic [3:0] rm);
    return {n, sk, 1'b0, rm};
  endfunction

  function automatic logic [11:0] sh_reg(logic [3:0] rs, shift_kind_t sk, logic [3:0] rm);
    return {rs, 1'b0, sk, 1'b1, rm};
  endfunction

  function automatic logic [WORD_W-1:0] pick_load_value();
    logic [WORD_W-1:0] picks [8];
    picks = '{32'd0, 32'd32, 32'd64, 32'd96, 32'd255, 32'd256, 32'hFFFF_FFFF, 32'h8000_0000};
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 40);
      1:       return picks[$urandom_range(0, 7)];
      default: return $urandom;
    endcase
  endfunction

  function automatic int idle_pct(bit sender);
    if (n_accepted < TOTAL_ITEMS / 3) return sender ? 22 : 64;
    else if (n_accepted < 2 * TOTAL_ITEMS / 3) return sender ? 64 : 22;
    return 0;
  endfunction

  // Driver: offers pending items, predicts each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(execute_item(drv_item));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          drv_item = pending_items.pop_front();
          in_kind          <= drv_item.kind;
          in_instruction   <= drv_item.instruction;
          in_load_index    <= drv_item.load_index;
          in_load_value    <= drv_item.load_value;
          in_mode_has_spsr <= drv_item.mode_has_spsr;
          in_saved_status  <= drv_item.saved_status;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest expectation, drives out_ready
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no item pending: dest_index %0d", out_dest_index);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (out_dest_index !== want.dest_index) begin
            $error("dest_index: expected %0d, got %0d", want.dest_index, out_dest_index);
            n_errors++;
          end
          if (out_dest_value !== want.dest_value) begin
            $error("dest_value: expected %h, got %h", want.dest_value, out_dest_value);
            n_errors++;
          end
          if (out_dest_written !== want.dest_written) begin
            $error("dest_written: expected %b, got %b", want.dest_written, out_dest_written);
            n_errors++;
          end
          if (out_flags_out !== want.flags_out) begin
            $error("flags_out: expected %b, got %b", want.flags_out, out_flags_out);
            n_errors++;
          end
          if (out_status_restored !== want.status_restored) begin
            $error("status_restored: expected %b, got %b", want.status_restored,
                   out_status_restored);
            n_errors++;
          end
          if (out_undefined_fault !== want.undefined_fault) begin
            $error("undefined_fault: expected %b, got %b", want.undefined_fault,
                   out_undefined_fault);
            n_errors++;
          end
        end
      end
      // one long back-pressure stretch so the pipe fills and in_ready drops
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && n_accepted >= 300) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [WORD_W-1:0] ins;
    for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
    nzcv = '0;

    // Directed: register extremes and shift amounts
    queue_load(4'd1, 32'hFFFF_FFFF);
    queue_load(4'd2, 32'h8000_0000);
    queue_load(4'd3, 32'h7FFF_FFFF);
    queue_load(4'd4, 32'd32);
    queue_load(4'd5, 32'd33);
    queue_load(4'd6, 32'd64);
    queue_load(4'd7, 32'd1);

    // Directed: every opcode, every shifter form
    queue_exec(dp_word(OP_AND, 1'b1, 4'd1, 4'd8, 1'b1, 12'hFFF), 1'b0, $urandom);
    queue_exec(dp_word(OP_EOR, 1'b1, 4'd1, 4'd8, 1'b0, sh_imm(5'd1, SH_LSL, 4'd2)), 1'b0,
               $urandom);
    queue_exec(dp_word(OP_SUB, 1'b1, 4'd2, 4'd9, 1'b0, sh_imm(5'd0, SH_LSL, 4'd7)), 1'b0,
               $urandom);
    queue_exec(dp_word(OP_RSB, 1'b1, 4'd7, 4'd9, 1'b0, sh_imm(5'd0, SH_LSR, 4'd2)), 1'b0,
               $urandom);
    queue_exec(dp_word(OP_ADD, 1'b1, 4'd3, 4'd10, 1'b0, sh_imm(5'd0, SH_LSL, 4'd7)), 1'b0,
               $urandom);
    queue_exec(dp_word(OP_ADC, 1'b1, 4'd1, 4'd10, 1'b0, sh_imm(5'd31, SH_LSR, 4'd2)), 1'b0,
               $urandom);
    queue_exec(dp_word(OP_SBC, 1'b1, 4'd0, 4'd11, 1'b0, sh_imm(5'd0, SH_ASR, 4'd1)), 1'b0,
               $urandom);
    queue_exec(dp_word(OP_RSC, 1'b1, 4'd1, 4'd11, 1'b0, sh_imm(5'd0, SH_ROR, 4'd7)), 1'b0,
               $urandom);
    queue_exec(dp_word(OP_TST, 1'b0, 4'd1, 4'd0, 1'b0, sh_reg(4'd4, SH_LSL, 4'd1)), 1'b0,
               $urandom);
    queue_exec(dp_word(OP_TEQ, 1'b0, 4'd2, 4'd15, 1'b0, sh_reg(4'd5, SH_LSR, 4'd2)), 1'b0,
               $urandom);
    queue_exec(dp_word(OP_CMP, 1'b1, 4'd3, 4'd15, 1'b0, sh_reg(4'd5, SH_ASR, 4'd3)), 1'b0,
               $urandom);
    // bit 7 set on a register-shifted operand is ignored
    queue_exec(dp_word(OP_CMN, 1'b1, 4'd1, 4'd0, 1'b0,
                       sh_reg(4'd6, SH_ROR, 4'd2) | 12'h080), 1'b1, $urandom);
    queue_exec(dp_word(OP_ORR, 1'b1, 4'd1, REG_PC, 1'b1, 12'h000), 1'b1,
               {4'hA, 28'(($urandom))});
    queue_exec(dp_word(OP_MOV, 1'b1, 4'd0, REG_PC, 1'b0, sh_imm(5'd3, SH_LSL, 4'd7)), 1'b0,
               $urandom);
    queue_exec(dp_word(OP_BIC, 1'b1, 4'd1, 4'd12, 1'b1, 12'h103), 1'b0, $urandom);
    queue_exec(dp_word(OP_MVN, 1'b0, 4'd0, 4'd13, 1'b0, sh_reg(4'd7, SH_ROR, 4'd3)), 1'b0,
               $urandom);

    // Random: mostly instructions on a file kept stocked with useful shift amounts
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(0, 99) < 22) begin
        queue_load(4'($urandom), pick_load_value());
      end else begin
        ins = $urandom;
        if ($urandom_range(0, 7) == 0) begin
          ins[20]    = 1'b1;
          ins[15:12] = REG_PC;
        end
        queue_exec(ins, 1'($urandom_range(0, 1)), $urandom);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d results: %0d register loads, %0d instructions executed.",
             n_checked, n_loads, n_execs);
    $display("Saw %0d SPSR flag restores and %0d undefined faults on S with Rd 15.",
             n_restores, n_faults);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/adpe_pkg.sv
rtl/adpe_ram.sv
rtl/arm_data_processing_execute.sv
bench/tb_arm_data_processing_execute.sv
